// ----- rtl/core/crtm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the CRT merge block.
// No dependencies; every other file of the block imports this package.
package crtm_pkg;

    localparam int ACC_WIDTH_DEF = 128;
    localparam int RES_W         = 64;
    localparam int MOD_W         = 63;
    localparam int WORD_W        = 64;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_MOD   = 2'd1;
    localparam logic [1:0] ST_NOT_COPRIME = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic [MOD_W-1:0] modulus;
        logic             last;
    } crtm_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] combined_residue_low;
        logic [WORD_W-1:0] combined_residue_high;
        logic [WORD_W-1:0] combined_modulus_low;
        logic [WORD_W-1:0] combined_modulus_high;
        logic [1:0]        status;
        logic              final_flag;
    } crtm_out_t;

    // Status of the serial multiplier toward the sequencer.
    typedef struct packed {
        logic done;
        logic ovf;
    } crtm_mul_stat_t;

    // One step of a shift-subtract reduction: (2*rem + bit) mod m, rem < m.
    function automatic logic [MOD_W-1:0] red_step(input logic [MOD_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W:0] v;
        v = {rem, bit_in};
        if (v >= {1'b0, m}) begin
            v = v - {1'b0, m};
        end
        return v[MOD_W-1:0];
    endfunction

    // One Horner step of a modular product: (2*acc + bit*add) mod m, acc, add < m.
    function automatic logic [MOD_W-1:0] mod_horner(input logic [MOD_W-1:0] acc,
                                                   input logic bit_in,
                                                   input logic [MOD_W-1:0] add,
                                                   input logic [MOD_W-1:0] m);
        logic [MOD_W+1:0] s;
        logic [MOD_W+1:0] m1;
        logic [MOD_W+1:0] m2;
        s  = {1'b0, acc, 1'b0} + {2'b00, (bit_in ? add : {MOD_W{1'b0}})};
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (s >= m2) begin
            s = s - m2;
        end else if (s >= m1) begin
            s = s - m1;
        end
        return s[MOD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/crtm_wmul.sv -----
// Bit-serial multiplier: wide accumulator value times a 63-bit scalar,
// one multiplier bit per cycle, with sticky overflow. Depends on crtm_pkg.
module crtm_wmul
    import crtm_pkg::*;
#(
    parameter int ACC_W = ACC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [ACC_W-1:0]     mcand,
    input  logic [MOD_W-1:0]     mplier,
    output logic [ACC_W-1:0]     product,
    output crtm_mul_stat_t       stat
);

    localparam int CW = $clog2(MOD_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [MOD_W-1:0]  sh_reg, sh_next;
    logic [ACC_W-1:0]  prod_reg, prod_next;
    logic [ACC_W+1:0]  sum;

    always_comb begin
        sum = {1'b0, prod_reg, 1'b0}
            + {2'b00, (sh_reg[MOD_W-1] ? mcand : {ACC_W{1'b0}})};
        run_next  = run_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        prod_next = prod_reg;
        if (start) begin
            run_next  = 1'b1;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            sh_next   = mplier;
            prod_next = '0;
        end else if (run_reg) begin
            // Horner intermediates never exceed the final product, so a
            // carry past the top at any step means the product overflows.
            prod_next = sum[ACC_W-1:0];
            ovf_next  = ovf_reg | (sum[ACC_W+1:ACC_W] != 2'b00);
            sh_next   = {sh_reg[MOD_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(MOD_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        ovf_reg  <= ovf_next;
        cnt_reg  <= cnt_next;
        sh_reg   <= sh_next;
        prod_reg <= prod_next;
    end

    assign product  = prod_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

// ----- rtl/core/crt_merge_coprime_128.sv -----
// Top level of the CRT merge block: sequencer, serial reducers and Euclid unit.
// Depends on crtm_pkg and instantiates crtm_wmul.
//
// This block folds a stream of congruences (residue, modulus) into a running
// solution R mod M, starting from R = 0 and M = 1, and returns one result
// transfer per input transfer carrying R and M as 64-bit halves plus a
// status code. A zero modulus, a modulus that is not coprime to M, or a
// product M*m wider than ACC_WIDTH bits leaves the state untouched and is
// flagged in status. An input with last set returns the state and then
// clears it. The block works on one pair at a time; its reductions, Euclid
// steps and products are bit serial. A pair first reduces M, R and the
// residue modulo m, then runs extended Euclid steps (one restoring-division
// bit per cycle, with the quotient folded into the Bezout coefficient by a
// Horner step), then forms the overflow product, the digit t and the
// product M*t, then does the final add and loads the result register. A
// pair with a zero modulus skips all arithmetic and goes straight to the
// result. The Euclid step count depends on the operands, at most about 90
// for 63-bit moduli. A new input transfer is taken while a finished result
// still waits in the output register.

module crt_merge_coprime_128
    import crtm_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  crtm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output crtm_out_t m_data
);

    localparam int CNT_W = $clog2(ACC_WIDTH + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RED    = 9'b000000010,
        S_EUC    = 9'b000000100,
        S_EUCEND = 9'b000001000,
        S_MULM   = 9'b000010000,
        S_TMUL   = 9'b000100000,
        S_MULT   = 9'b001000000,
        S_ADD    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [MOD_W-1:0]     mod_reg, mod_next;
    logic                 last_reg, last_next;
    logic [ACC_WIDTH-1:0] accr_reg, accr_next;
    logic [ACC_WIDTH-1:0] accm_reg, accm_next;
    logic [ACC_WIDTH-1:0] sha_reg, sha_next;
    logic [ACC_WIDTH-1:0] shr_reg, shr_next;
    logic [ACC_WIDTH-1:0] newm_reg, newm_next;
    logic [RES_W-1:0]     rsh_reg, rsh_next;
    logic [MOD_W-1:0]     rema_reg, rema_next;
    logic [MOD_W-1:0]     remr_reg, remr_next;
    logic [MOD_W-1:0]     remi_reg, remi_next;
    logic [MOD_W-1:0]     g1_reg, g1_next;
    logic [MOD_W-1:0]     s0_reg, s0_next;
    logic [MOD_W-1:0]     s1_reg, s1_next;
    logic [MOD_W-1:0]     dvd_reg, dvd_next;
    logic [MOD_W-1:0]     rem_reg, rem_next;
    logic [MOD_W-1:0]     qs_reg, qs_next;
    logic                 qbit_reg, qbit_next;
    logic [MOD_W-1:0]     tsh_reg, tsh_next;
    logic [MOD_W-1:0]     tacc_reg, tacc_next;
    logic [MOD_W-1:0]     delta_reg, delta_next;
    logic [1:0]           status_reg, status_next;
    logic                 mv_reg, mv_next;
    logic                 mstart_reg, mstart_next;
    crtm_out_t            out_reg, out_next;

    logic [MOD_W-1:0]     ra_n;
    logic [MOD_W:0]       dv;
    logic [MOD_W-1:0]     ts;
    logic [ACC_WIDTH+WORD_W-1:0] r_ext;
    logic [ACC_WIDTH+WORD_W-1:0] m_ext;

    logic [ACC_WIDTH-1:0] mul_prod;
    logic [MOD_W-1:0]     mul_mplier;
    crtm_mul_stat_t       mul_stat;

    assign mul_mplier = (state_reg == S_MULM) ? mod_reg : tacc_reg;

    crtm_wmul #(
        .ACC_W (ACC_WIDTH)
    ) u_wmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart_reg),
        .mcand   (accm_reg),
        .mplier  (mul_mplier),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mod_next    = mod_reg;
        last_next   = last_reg;
        accr_next   = accr_reg;
        accm_next   = accm_reg;
        sha_next    = sha_reg;
        shr_next    = shr_reg;
        newm_next   = newm_reg;
        rsh_next    = rsh_reg;
        rema_next   = rema_reg;
        remr_next   = remr_reg;
        remi_next   = remi_reg;
        g1_next     = g1_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        qs_next     = qs_reg;
        qbit_next   = qbit_reg;
        tsh_next    = tsh_reg;
        tacc_next   = tacc_reg;
        delta_next  = delta_reg;
        status_next = status_reg;
        mv_next     = mv_reg;
        mstart_next = 1'b0;
        out_next    = out_reg;

        ra_n  = red_step(rema_reg, sha_reg[ACC_WIDTH-1], mod_reg);
        dv    = {rem_reg, dvd_reg[MOD_W-1]};
        ts    = (s0_reg >= qs_reg) ? (s0_reg - qs_reg) : (s0_reg + (mod_reg - qs_reg));
        r_ext = {{WORD_W{1'b0}}, accr_reg};
        m_ext = {{WORD_W{1'b0}}, accm_reg};

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mod_next  = s_data.modulus;
                    last_next = s_data.last;
                    sha_next  = accm_reg;
                    shr_next  = accr_reg;
                    rsh_next  = s_data.residue;
                    rema_next = '0;
                    remr_next = '0;
                    remi_next = '0;
                    cnt_next  = '0;
                    if (s_data.modulus == '0) begin
                        status_next = ST_ZERO_MOD;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_RED;
                    end
                end
            end
            S_RED: begin
                // M, R and the residue are reduced modulo m side by side.
                rema_next = ra_n;
                remr_next = red_step(remr_reg, shr_reg[ACC_WIDTH-1], mod_reg);
                sha_next  = {sha_reg[ACC_WIDTH-2:0], 1'b0};
                shr_next  = {shr_reg[ACC_WIDTH-2:0], 1'b0};
                if (cnt_reg < CNT_W'(RES_W)) begin
                    remi_next = red_step(remi_reg, rsh_reg[RES_W-1], mod_reg);
                    rsh_next  = {rsh_reg[RES_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_WIDTH - 1)) begin
                    dvd_next   = ra_n;
                    g1_next    = mod_reg;
                    s0_next    = (mod_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
                    s1_next    = '0;
                    rem_next   = '0;
                    qs_next    = '0;
                    qbit_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_EUC;
                end
            end
            S_EUC: begin
                // Quotient bits come out MSB first; the Horner step folds each bit into
                // q*s1 mod m in the cycle after the divider produces it.
                qs_next = mod_horner(qs_reg, qbit_reg, s1_reg, mod_reg);
                if (cnt_reg < CNT_W'(MOD_W)) begin
                    if (dv >= {1'b0, g1_reg}) begin
                        rem_next  = dv[MOD_W-1:0] - g1_reg;
                        qbit_next = 1'b1;
                    end else begin
                        rem_next  = dv[MOD_W-1:0];
                        qbit_next = 1'b0;
                    end
                    dvd_next = {dvd_reg[MOD_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    state_next = S_EUCEND;
                end
            end
            S_EUCEND: begin
                if (rem_reg == '0) begin
                    if (g1_reg != MOD_W'(1)) begin
                        status_next = ST_NOT_COPRIME;
                        state_next  = S_OUT;
                    end else begin
                        tsh_next    = s1_reg;
                        mstart_next = 1'b1;
                        state_next  = S_MULM;
                    end
                end else begin
                    dvd_next   = g1_reg;
                    g1_next    = rem_reg;
                    s0_next    = s1_reg;
                    s1_next    = ts;
                    rem_next   = '0;
                    qs_next    = '0;
                    qbit_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_EUC;
                end
            end
            S_MULM: begin
                if (mul_stat.done) begin
                    if (mul_stat.ovf) begin
                        status_next = ST_OVERFLOW;
                        state_next  = S_OUT;
                    end else begin
                        newm_next  = mul_prod;
                        delta_next = (remi_reg >= remr_reg) ? (remi_reg - remr_reg)
                                   : (remi_reg + (mod_reg - remr_reg));
                        tacc_next  = '0;
                        cnt_next   = '0;
                        state_next = S_TMUL;
                    end
                end
            end
            S_TMUL: begin
                tacc_next = mod_horner(tacc_reg, tsh_reg[MOD_W-1], delta_reg, mod_reg);
                tsh_next  = {tsh_reg[MOD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MOD_W - 1)) begin
                    mstart_next = 1'b1;
                    state_next  = S_MULT;
                end
            end
            S_MULT: begin
                if (mul_stat.done) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                accr_next   = accr_reg + mul_prod;
                accm_next   = newm_reg;
                status_next = ST_OK;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    out_next.combined_residue_low  = r_ext[WORD_W-1:0];
                    out_next.combined_residue_high = r_ext[2*WORD_W-1:WORD_W];
                    out_next.combined_modulus_low  = m_ext[WORD_W-1:0];
                    out_next.combined_modulus_high = m_ext[2*WORD_W-1:WORD_W];
                    out_next.status                = status_reg;
                    out_next.final_flag            = last_reg;
                    mv_next = 1'b1;
                    if (last_reg) begin
                        accr_next = '0;
                        accm_next = ACC_WIDTH'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mv_reg     <= 1'b0;
            mstart_reg <= 1'b0;
            accr_reg   <= '0;
            accm_reg   <= ACC_WIDTH'(1);
        end else begin
            state_reg  <= state_next;
            mv_reg     <= mv_next;
            mstart_reg <= mstart_next;
            accr_reg   <= accr_next;
            accm_reg   <= accm_next;
        end
        cnt_reg    <= cnt_next;
        mod_reg    <= mod_next;
        last_reg   <= last_next;
        sha_reg    <= sha_next;
        shr_reg    <= shr_next;
        newm_reg   <= newm_next;
        rsh_reg    <= rsh_next;
        rema_reg   <= rema_next;
        remr_reg   <= remr_next;
        remi_reg   <= remi_next;
        g1_reg     <= g1_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        qs_reg     <= qs_next;
        qbit_reg   <= qbit_next;
        tsh_reg    <= tsh_next;
        tacc_reg   <= tacc_next;
        delta_reg  <= delta_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    // A zero modulus skips all arithmetic and goes straight to the result.
    a_zero_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.modulus == '0)) |=> (state_reg == S_OUT))
        else $error("zero modulus did not go straight to the result");

    // Only one pair is in flight: an input transfer closes the input side.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a pair is in flight");

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> ((state_reg == S_MULM) || (state_reg == S_MULT)))
        else $error("multiplier finished outside a multiply phase");

endmodule
